@@ hdl/mmr_pkg.sv @@
// ----------------------------------------------------------------------------
// mmr_pkg: shared types and constants of the mailbox ring
// sizes, item layouts, codes and pointer helpers used by every module
// ----------------------------------------------------------------------------
package mmr_pkg;

   localparam int BOXES     = 4;
   localparam int BUF_BYTES = 64;
   localparam int MAX_OUT   = 64;

   localparam int BOX_W  = 2;
   localparam int LEN_W  = 7;
   localparam int BYTE_W = 8;

   localparam int PTR_W  = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
   localparam int CNT_W  = $clog2(BUF_BYTES + 1);
   localparam int DEPTH  = BOXES * BUF_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int MAX_W  = (PTR_W > LEN_W) ? ((PTR_W > CNT_W) ? PTR_W : CNT_W)
                                           : ((LEN_W > CNT_W) ? LEN_W : CNT_W);
   localparam int WIDE_W = MAX_W + 1;

   localparam logic OP_SEND = 1'b0;
   localparam logic OP_RECV = 1'b1;

   localparam logic ST_DONE  = 1'b0;
   localparam logic ST_BLOCK = 1'b1;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [WIDE_W-1:0] wide_type;

   typedef struct packed {
      logic              operation;
      logic [BOX_W-1:0]  box;
      logic [LEN_W-1:0]  length;
      logic              first_byte;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              status;
      logic              last;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_send;
      logic load_short;
      logic start_recv;
      logic load_byte;
      logic next_read;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic recv_go;
      logic rd_last;
   } stat_type;

   function automatic ptr_type next_ptr(input ptr_type p);
      ptr_type r;
      if (p == PTR_W'(BUF_BYTES - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   function automatic addr_type store_addr(input logic [BOX_W-1:0] b, input ptr_type p);
      addr_type r;
      r = ADDR_W'(int'(b) * BUF_BYTES) + ADDR_W'(p);
      return r;
   endfunction

endpackage

@@ hdl/mmr_dpath.sv @@
// ----------------------------------------------------------------------------
// mmr_dpath: mailbox ring datapath
// byte store, per-box head, tail and fill, send tracking and result register
// ----------------------------------------------------------------------------
module mmr_dpath (
   input  logic             clock,
   input  logic             reset,
   input  mmr_pkg::req_type req_data,
   input  mmr_pkg::cmd_type cmd,
   output mmr_pkg::stat_type stat,
   output mmr_pkg::rsp_type rsp_data
);

   logic [mmr_pkg::BYTE_W-1:0] store_ff [0:mmr_pkg::DEPTH-1];
   logic [mmr_pkg::BYTE_W-1:0] rd_data_ff;

   mmr_pkg::ptr_type head_ff [0:mmr_pkg::BOXES-1];
   mmr_pkg::ptr_type tail_ff [0:mmr_pkg::BOXES-1];
   mmr_pkg::cnt_type fill_ff [0:mmr_pkg::BOXES-1];

   logic [mmr_pkg::LEN_W-1:0] send_rem_ff, send_rem_in;
   logic                      send_acc_ff, send_acc_in;

   mmr_pkg::ptr_type          rd_ptr_ff;
   logic [mmr_pkg::BOX_W-1:0] rd_box_ff;
   logic [mmr_pkg::LEN_W-1:0] rd_rem_ff;

   mmr_pkg::rsp_type rsp_ff;

   logic                      valid_box;
   mmr_pkg::cnt_type          fill_sel;
   mmr_pkg::ptr_type          head_sel;
   mmr_pkg::ptr_type          tail_sel;
   mmr_pkg::wide_type         len_w;
   mmr_pkg::wide_type         space;
   mmr_pkg::wide_type         head_sum;
   mmr_pkg::ptr_type          head_new;
   logic [mmr_pkg::LEN_W-1:0] rem_eff;
   logic                      acc_eff;
   logic                      wr_en;
   logic                      rd_en;
   mmr_pkg::addr_type         rd_addr;

   assign valid_box = int'(req_data.box) < mmr_pkg::BOXES;
   assign fill_sel  = fill_ff[req_data.box];
   assign head_sel  = head_ff[req_data.box];
   assign tail_sel  = tail_ff[req_data.box];
   assign len_w     = mmr_pkg::WIDE_W'(req_data.length);
   assign space     = mmr_pkg::WIDE_W'(mmr_pkg::BUF_BYTES) - mmr_pkg::WIDE_W'(fill_sel);

   // send: a first byte opens a message, accepted whole or refused whole
   always_comb begin
      if (req_data.first_byte) begin
         rem_eff = req_data.length;
         acc_eff = valid_box && (req_data.length != '0) && (space >= len_w);
      end else begin
         rem_eff = send_rem_ff;
         acc_eff = send_acc_ff;
      end
      wr_en       = 1'b0;
      send_rem_in = rem_eff;
      send_acc_in = acc_eff;
      if (rem_eff != '0) begin
         send_rem_in = rem_eff - mmr_pkg::LEN_W'(1);
         wr_en       = acc_eff && valid_box &&
                       (fill_sel != mmr_pkg::CNT_W'(mmr_pkg::BUF_BYTES));
         if (send_rem_in == '0) begin
            send_acc_in = 1'b0;
         end
      end
   end

   // receive: head moves by the whole length at the start
   assign head_sum = mmr_pkg::WIDE_W'(head_sel) + len_w;
   assign head_new = (head_sum >= mmr_pkg::WIDE_W'(mmr_pkg::BUF_BYTES))
                   ? mmr_pkg::PTR_W'(head_sum - mmr_pkg::WIDE_W'(mmr_pkg::BUF_BYTES))
                   : mmr_pkg::PTR_W'(head_sum);

   assign stat.recv_go = (req_data.length != '0) && valid_box &&
                         (len_w <= mmr_pkg::WIDE_W'(mmr_pkg::MAX_OUT)) &&
                         (mmr_pkg::WIDE_W'(fill_sel) >= len_w);
   assign stat.rd_last = rd_rem_ff == mmr_pkg::LEN_W'(1);

   assign rd_en   = cmd.start_recv || cmd.next_read;
   assign rd_addr = cmd.start_recv ? mmr_pkg::store_addr(req_data.box, head_sel)
                                   : mmr_pkg::store_addr(rd_box_ff, rd_ptr_ff);

   // byte store
   always_ff @(posedge clock) begin
      if (cmd.load_send && wr_en) begin
         store_ff[mmr_pkg::store_addr(req_data.box, tail_sel)] <= req_data.data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // box pointers and send tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mmr_pkg::BOXES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         send_rem_ff <= '0;
         send_acc_ff <= 1'b0;
      end else begin
         if (cmd.load_send) begin
            send_rem_ff <= send_rem_in;
            send_acc_ff <= send_acc_in;
            if (wr_en) begin
               tail_ff[req_data.box] <= mmr_pkg::next_ptr(tail_sel);
               fill_ff[req_data.box] <= fill_sel + mmr_pkg::CNT_W'(1);
            end
         end
         if (cmd.start_recv) begin
            head_ff[req_data.box] <= head_new;
            fill_ff[req_data.box] <= mmr_pkg::CNT_W'(mmr_pkg::WIDE_W'(fill_sel) - len_w);
         end
      end
   end

   // read walk and result register
   always_ff @(posedge clock) begin
      if (cmd.start_recv) begin
         rd_ptr_ff <= mmr_pkg::next_ptr(head_sel);
         rd_box_ff <= req_data.box;
         rd_rem_ff <= req_data.length;
      end else if (cmd.load_byte) begin
         rd_rem_ff <= rd_rem_ff - mmr_pkg::LEN_W'(1);
         if (cmd.next_read) begin
            rd_ptr_ff <= mmr_pkg::next_ptr(rd_ptr_ff);
         end
      end
      if (cmd.load_send) begin
         rsp_ff.out_byte <= '0;
         rsp_ff.status   <= wr_en ? mmr_pkg::ST_DONE : mmr_pkg::ST_BLOCK;
         rsp_ff.last     <= 1'b1;
      end else if (cmd.load_short) begin
         rsp_ff.out_byte <= '0;
         rsp_ff.status   <= (req_data.length == '0) ? mmr_pkg::ST_DONE : mmr_pkg::ST_BLOCK;
         rsp_ff.last     <= 1'b1;
      end else if (cmd.load_byte) begin
         rsp_ff.out_byte <= rd_data_ff;
         rsp_ff.status   <= mmr_pkg::ST_DONE;
         rsp_ff.last     <= stat.rd_last;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ hdl/mmr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmr_ctrl: mailbox ring controller
// input acceptance, receive streaming and the result valid flag
// ----------------------------------------------------------------------------
module mmr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_op,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  mmr_pkg::stat_type stat,
   output mmr_pkg::cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_STREAM
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.load_send  = accept && (req_op == mmr_pkg::OP_SEND);
      cmd.start_recv = accept && (req_op == mmr_pkg::OP_RECV) && stat.recv_go;
      cmd.load_short = accept && (req_op == mmr_pkg::OP_RECV) && !stat.recv_go;
      cmd.load_byte  = (state_ff == S_STREAM) && out_free;
      cmd.next_read  = cmd.load_byte && !stat.rd_last;

      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start_recv) begin
               state_in = S_STREAM;
            end
         end
         S_STREAM: begin
            if (cmd.load_byte && stat.rd_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.load_send || cmd.load_short || cmd.load_byte) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/message_mailbox_ring.sv @@
// a send byte or a refused/empty receive gives its item in the cycle after acceptance
// receive of n bytes: first byte via the store read register and the result register,
// then 1 byte per cycle while the output is free; input stalls for the whole stream
// throughput: 1 send byte per cycle while the output is free; the receive rate is set
// by the single registered read port of the byte store; reset clears head, tail and fill
// of every box and the send tracking, not the byte store, which needs no clearing pass
// ----------------------------------------------------------------------------
// message_mailbox_ring: set of circular byte mailboxes
// whole-message sends with a space check, fixed-length receives from the head
// ----------------------------------------------------------------------------
module message_mailbox_ring (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mmr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mmr_pkg::rsp_type rsp_data
);

   // command and status between the controller and the datapath
   mmr_pkg::cmd_type  cmd;
   mmr_pkg::stat_type stat;

   // controller: takes an item only when idle and the result register can be refilled,
   // then streams the bytes of an accepted receive one per cycle while the output is free
   mmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: byte store, per-box pointers and fill counts, result register
   mmr_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // only one source loads the result register in a cycle
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_send, cmd.load_short, cmd.load_byte}))
      else $error("result register loaded from two sources");

   // a follow-on read is only issued while a byte is being handed on
   a_read_chain: assert property (@(posedge clock) disable iff (reset)
      cmd.next_read |-> cmd.load_byte)
      else $error("store read issued without a byte delivered");

   // a receive starts only on an accepted receive item
   a_start_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.start_recv |-> (req_valid && !req_stall &&
                          (req_data.operation == mmr_pkg::OP_RECV)))
      else $error("receive started without an accepted item");

   // after a receive starts, its first byte is loaded as soon as the output is free
   a_stream_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.start_recv |=> (cmd.load_byte || (rsp_valid && rsp_stall)))
      else $error("receive stream stalled with a free output");

endmodule
